// File: sv/oimt_pkg.sv
// oimt_pkg: shared types, codes and sizing for the owner/item multimap table
// used by every module of the block and by the request channel interface
package oimt_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int AW = IW + 1;
	localparam int CMPW = (CW > 7) ? CW : 7;

	typedef enum logic [1:0] {
		OP_COUNT   = 2'd0,
		OP_GET_NTH = 2'd1,
		OP_APPEND  = 2'd2,
		OP_DELETE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		RS_OK        = 2'd0,
		RS_FULL      = 2'd1,
		RS_NOT_FOUND = 2'd2
	} res_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_POST,
		S_SHIFT,
		S_DONE
	} state_t;

	typedef struct packed {
		op_t               operation;
		logic              table_select;
		logic signed [15:0] owner_id;
		logic signed [15:0] item_id;
		logic [6:0]        nth_index;
	} req_t;

	typedef struct packed {
		logic [6:0]         match_count;
		logic signed [15:0] found_item;
		logic               found;
		res_status_t        status;
		logic [6:0]         table_size;
	} rsp_t;

	typedef struct packed {
		logic ready;
		logic load;
		logic issue;
		logic shift_mode;
		logic shift_init;
		logic commit;
	} ctl_cmd_t;

	typedef struct packed {
		op_t  op;
		logic scan_empty;
		logic last_data;
		logic hit;
		logic shift_none;
		logic out_busy;
	} dp_status_t;

	function automatic logic [6:0] sat7(logic [CW-1:0] v);
		logic [CW+6:0] ext;
		ext = (CW + 7)'(v);
		if (ext > (CW + 7)'(127)) begin
			sat7 = 7'h7f;
		end else begin
			sat7 = ext[6:0];
		end
	endfunction

endpackage

// File: sv/oimt_req_if.sv
// oimt_req_if: request channel, valid/ready plus one operation word
// depends on oimt_pkg for the operation code type
interface oimt_req_if;
	import oimt_pkg::*;

	logic               valid;
	logic               ready;
	op_t                operation;
	logic               table_select;
	logic signed [15:0] owner_id;
	logic signed [15:0] item_id;
	logic [6:0]         nth_index;

	modport source (output valid, operation, table_select, owner_id, item_id, nth_index,
		input ready);
	modport sink (input valid, operation, table_select, owner_id, item_id, nth_index,
		output ready);
endinterface

// File: sv/oimt_rsp_if.sv
// oimt_rsp_if: response channel, valid/ready plus one result word
// standalone, no package needed
interface oimt_rsp_if;
	logic               valid;
	logic               ready;
	logic [6:0]         match_count;
	logic signed [15:0] found_item;
	logic               found;
	logic [1:0]         status;
	logic [6:0]         table_size;

	modport source (output valid, match_count, found_item, found, status, table_size,
		input ready);
	modport sink (input valid, match_count, found_item, found, status, table_size,
		output ready);
endinterface

// File: sv/oimt_ctrl.sv
// oimt_ctrl: sequencer for scan, gap-closing shift and result commit
// depends on oimt_pkg for state, command and status types
module oimt_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	input  oimt_pkg::dp_status_t  st,
	output oimt_pkg::ctl_cmd_t    cmd
);
	import oimt_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (st.op == OP_APPEND) begin
					state_d = S_DONE;
				end else begin
					cmd.issue = 1'b1;
					if (st.scan_empty || st.last_data) begin
						state_d = S_POST;
					end
				end
			end
			S_POST: begin
				if (st.op == OP_DELETE && st.hit) begin
					cmd.shift_init = 1'b1;
					state_d = S_SHIFT;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SHIFT: begin
				cmd.issue = 1'b1;
				cmd.shift_mode = 1'b1;
				if (st.shift_none || st.last_data) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!st.out_busy) begin
					cmd.commit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// File: sv/oimt_datapath.sv
// oimt_datapath: table memory, fill counts, scan compare, shift and result register
// depends on oimt_pkg for sizing, codes and the command/status structs
module oimt_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  oimt_pkg::req_t        req,
	input  oimt_pkg::ctl_cmd_t    cmd,
	output oimt_pkg::dp_status_t  st,
	input  logic                  rsp_ready,
	output logic                  rsp_valid,
	output oimt_pkg::rsp_t        rsp
);
	import oimt_pkg::*;

	logic [31:0]        mem [2**AW];

	op_t                op_q;
	logic               sel_q;
	logic signed [15:0] owner_q;
	logic signed [15:0] item_q;
	logic [6:0]         nth_q;
	logic [CW-1:0]      n_q;
	logic [CW-1:0]      rd_idx_q;
	logic [CW-1:0]      seen_q;
	logic               found_q;
	logic signed [15:0] fitem_q;
	logic               hit_q;
	logic [IW-1:0]      pos_q;
	logic [CW-1:0]      fill_q [2];
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic               v_s1;
	logic [IW-1:0]      idx_s1;
	logic [31:0]        rdata_s1;

	logic               issue_go;
	logic               scan_v;
	logic               owner_hit;
	logic               nth_match;
	logic               full;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [31:0]        wr_data;
	logic [CW-1:0]      n_new;
	rsp_t               res;

	assign issue_go  = cmd.issue && (rd_idx_q < n_q);
	assign scan_v    = v_s1 && !cmd.shift_mode;
	assign owner_hit = (rdata_s1[31:16] == owner_q);
	assign nth_match = scan_v && owner_hit && !found_q &&
		((CMPW'(seen_q) + CMPW'(1)) == CMPW'(nth_q));
	assign full      = (n_q >= CW'(TABLE_DEPTH));

	// table memory, one read and one write port
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = {sel_q, n_q[IW-1:0]};
		wr_data = {owner_q, item_q};
		if (cmd.shift_mode) begin
			wr_en   = v_s1;
			wr_addr = {sel_q, idx_s1 - IW'(1)};
			wr_data = rdata_s1;
		end else if (cmd.commit && op_q == OP_APPEND && !full) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (issue_go) begin
			rdata_s1 <= mem[{sel_q, rd_idx_q[IW-1:0]}];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			fill_q[0]   <= '0;
			fill_q[1]   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			v_s1 <= issue_go;
			if (cmd.commit) begin
				fill_q[sel_q] <= n_new;
				rsp_valid_q   <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q[IW-1:0];
		if (cmd.load) begin
			op_q     <= req.operation;
			sel_q    <= req.table_select;
			owner_q  <= req.owner_id;
			item_q   <= req.item_id;
			nth_q    <= req.nth_index;
			n_q      <= fill_q[req.table_select];
			rd_idx_q <= '0;
			seen_q   <= '0;
			found_q  <= 1'b0;
			fitem_q  <= '0;
			hit_q    <= 1'b0;
			pos_q    <= '0;
		end else begin
			if (cmd.shift_init) begin
				rd_idx_q <= CW'(pos_q) + CW'(1);
			end else if (issue_go) begin
				rd_idx_q <= rd_idx_q + CW'(1);
			end
			if (scan_v && owner_hit) begin
				seen_q <= seen_q + CW'(1);
			end
			if (nth_match) begin
				found_q <= 1'b1;
				fitem_q <= rdata_s1[15:0];
			end
			if (scan_v && rdata_s1 == {owner_q, item_q}) begin
				hit_q <= 1'b1;
				pos_q <= idx_s1;
			end
		end
		if (cmd.commit) begin
			rsp_q <= res;
		end
	end

	always_comb begin
		n_new = n_q;
		res = '0;
		res.status = RS_OK;
		unique case (op_q)
			OP_COUNT: begin
				res.match_count = sat7(seen_q);
			end
			OP_GET_NTH: begin
				res.found      = found_q;
				res.found_item = found_q ? fitem_q : 16'sd0;
				res.status     = found_q ? RS_OK : RS_NOT_FOUND;
			end
			OP_APPEND: begin
				if (full) begin
					res.status = RS_FULL;
				end else begin
					n_new = n_q + CW'(1);
				end
			end
			OP_DELETE: begin
				if (hit_q) begin
					n_new     = n_q - CW'(1);
					res.found = 1'b1;
				end else begin
					res.status = RS_NOT_FOUND;
				end
			end
			default: begin
				n_new = n_q;
			end
		endcase
		res.table_size = sat7(n_new);
	end

	assign st.op         = op_q;
	assign st.scan_empty = (n_q == '0);
	assign st.last_data  = v_s1 && (CW'(idx_s1) == n_q - CW'(1));
	assign st.hit        = hit_q;
	assign st.shift_none = ((CW'(pos_q) + CW'(1)) == n_q);
	assign st.out_busy   = rsp_valid_q && !rsp_ready;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: sv/owner_item_multimap_table_core.sv
// owner_item_multimap_table_core: top level, player and enemy owner/item tables
// depends on oimt_pkg, oimt_req_if, oimt_rsp_if, oimt_ctrl and oimt_datapath
//
// Two insertion-ordered tables of (owner, item) words share one memory with a
// single read port, so count, get-nth and delete walk the selected table one
// entry per cycle; append does not walk the table. A delete that hits moves
// the later entries down one place. One operation is in flight at a time;
// the result sits in an output register, and the next word is accepted once
// the current one has been committed there.
module owner_item_multimap_table_core (
	input  logic clk,
	input  logic arst_n,
	oimt_req_if.sink   request,
	oimt_rsp_if.source response
);
	import oimt_pkg::*;

	req_t       req;
	rsp_t       rsp;
	logic       rsp_valid;
	ctl_cmd_t   cmd;
	dp_status_t st;

	assign req.operation    = request.operation;
	assign req.table_select = request.table_select;
	assign req.owner_id     = request.owner_id;
	assign req.item_id      = request.item_id;
	assign req.nth_index    = request.nth_index;
	assign request.ready    = cmd.ready;

	oimt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (request.valid),
		.st        (st),
		.cmd       (cmd)
	);

	oimt_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.st        (st),
		.rsp_ready (response.ready),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

	assign response.valid       = rsp_valid;
	assign response.match_count = rsp.match_count;
	assign response.found_item  = rsp.found_item;
	assign response.found       = rsp.found;
	assign response.status      = rsp.status;
	assign response.table_size  = rsp.table_size;

endmodule

// File: sim/owner_item_multimap_table_core_tb.sv
// owner_item_multimap_table_core_tb: checks owner/item table results against an in-bench table model
// drives the request channel and drains the response channel with random idle and stall cycles
// depends on oimt_pkg, oimt_req_if, oimt_rsp_if and owner_item_multimap_table_core
module owner_item_multimap_table_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import oimt_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n;

	oimt_req_if req_ch();
	oimt_rsp_if rsp_ch();

	owner_item_multimap_table_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.request(req_ch),
		.response(rsp_ch)
	);

	always #4 clk = ~clk;

	logic [31:0] unit_tbl [2][TABLE_DEPTH];
	int unit_fill [2];
	rsp_t pending_results [$];
	logic [15:0] owner_pool [6] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001, 16'h5a5a};

	int err_count = 0;
	int cycle_count = 0;
	int req_idle_pct = 33;
	int rsp_idle_pct = 33;
	int hold_left = 0;

	// table model: one operation on the selected table, returns the result word
	function automatic rsp_t apply_table_op(op_t op, logic sel, logic [15:0] own,
		logic [15:0] itm, logic [6:0] nth);
		rsp_t r;
		int n;
		int seen;
		int pos;
		int i;
		logic [31:0] key;
		r = '0;
		n = unit_fill[sel];
		key = {own, itm};
		seen = 0;
		pos = -1;
		case (op)
			OP_COUNT: begin
				for (i = 0; i < n; i++) begin
					if (unit_tbl[sel][i][31:16] == own) seen++;
				end
				r.match_count = 7'(seen);
			end
			OP_GET_NTH: begin
				r.status = RS_NOT_FOUND;
				if (nth != 7'd0) begin
					for (i = 0; i < n; i++) begin
						if (unit_tbl[sel][i][31:16] == own && !r.found) begin
							seen++;
							if (seen == int'(nth)) begin
								r.found_item = unit_tbl[sel][i][15:0];
								r.found = 1'b1;
								r.status = RS_OK;
							end
						end
					end
				end
			end
			OP_APPEND: begin
				if (n >= TABLE_DEPTH) begin
					r.status = RS_FULL;
				end else begin
					unit_tbl[sel][n] = key;
					n++;
				end
			end
			default: begin
				for (i = 0; i < n; i++) begin
					if (unit_tbl[sel][i] == key) pos = i;
				end
				if (pos >= 0) begin
					for (i = pos; i + 1 < n; i++) unit_tbl[sel][i] = unit_tbl[sel][i + 1];
					n--;
					r.found = 1'b1;
				end else begin
					r.status = RS_NOT_FOUND;
				end
			end
		endcase
		unit_fill[sel] = n;
		r.table_size = 7'(n);
		return r;
	endfunction

	// called at a falling edge, returns at the falling edge after the word is taken
	task automatic send_word(op_t op, logic sel, logic [15:0] own, logic [15:0] itm,
		logic [6:0] nth);
		while ($urandom_range(0, 99) < req_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.operation <= op;
		req_ch.table_select <= sel;
		req_ch.owner_id <= own;
		req_ch.item_id <= itm;
		req_ch.nth_index <= nth;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		pending_results.push_back(apply_table_op(op, sel, own, itm, nth));
		@(negedge clk);
	endtask

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			err_count++;
			$display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			rsp_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
		end
	end

	always @(posedge clk) begin : check_results
		rsp_t want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				err_count++;
				$display("%0t: word with none pending, expected nothing, actual %0h %0h %0h %0h %0h",
					$time, rsp_ch.match_count, rsp_ch.found_item, rsp_ch.found,
					rsp_ch.status, rsp_ch.table_size);
			end else begin
				want = pending_results.pop_front();
				check_field("match_count", 16'(want.match_count), 16'(rsp_ch.match_count));
				check_field("found_item", want.found_item, rsp_ch.found_item);
				check_field("found", 16'(want.found), 16'(rsp_ch.found));
				check_field("status", 16'(want.status), 16'(rsp_ch.status));
				check_field("table_size", 16'(want.table_size), 16'(rsp_ch.table_size));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic test_directed;
		send_word(OP_COUNT, 1'b0, 16'h0000, 16'h0000, 7'd0);
		send_word(OP_GET_NTH, 1'b0, 16'h0000, 16'h0000, 7'd0);
		send_word(OP_DELETE, 1'b0, 16'h8000, 16'h7fff, 7'd0);
		send_word(OP_APPEND, 1'b0, 16'h8000, 16'h7fff, 7'd0);
		send_word(OP_APPEND, 1'b0, 16'h7fff, 16'h8000, 7'd0);
		send_word(OP_APPEND, 1'b0, 16'h8000, 16'h0000, 7'd0);
		send_word(OP_APPEND, 1'b0, 16'hffff, 16'hffff, 7'd0);
		send_word(OP_APPEND, 1'b0, 16'h8000, 16'h7fff, 7'd0);
		send_word(OP_COUNT, 1'b0, 16'h8000, 16'h0000, 7'd0);
		send_word(OP_GET_NTH, 1'b0, 16'h8000, 16'h0000, 7'd2);
		send_word(OP_GET_NTH, 1'b0, 16'h8000, 16'h0000, 7'd3);
		send_word(OP_GET_NTH, 1'b0, 16'h8000, 16'h0000, 7'd4);
		send_word(OP_GET_NTH, 1'b0, 16'h8000, 16'h0000, 7'd0);
		send_word(OP_GET_NTH, 1'b0, 16'h8000, 16'h0000, 7'd64);
		send_word(OP_DELETE, 1'b0, 16'h8000, 16'h7fff, 7'd0);
		send_word(OP_DELETE, 1'b0, 16'h7fff, 16'h8000, 7'd0);
		send_word(OP_DELETE, 1'b0, 16'h1234, 16'h1234, 7'd0);
		send_word(OP_COUNT, 1'b1, 16'h8000, 16'h0000, 7'd0);
		send_word(OP_APPEND, 1'b1, 16'h8000, 16'h1234, 7'd0);
		send_word(OP_GET_NTH, 1'b1, 16'h8000, 16'h0000, 7'd1);
		send_word(OP_COUNT, 1'b0, 16'hffff, 16'h0000, 7'd0);
		send_word(OP_DELETE, 1'b1, 16'h8000, 16'h1234, 7'd0);
		send_word(OP_GET_NTH, 1'b0, 16'hffff, 16'h0000, 7'd1);
	endtask

	task automatic test_table_full;
		int s;
		int k;
		int idx;
		logic sel;
		for (s = 0; s < 2; s++) begin
			sel = 1'(s);
			while (unit_fill[sel] > 0)
				send_word(OP_DELETE, sel, unit_tbl[sel][0][31:16], unit_tbl[sel][0][15:0], 7'd0);
			for (k = 0; k < TABLE_DEPTH; k++)
				send_word(OP_APPEND, sel, 16'h2a2a, 16'($urandom), 7'($urandom));
			send_word(OP_APPEND, sel, 16'h1111, 16'h2222, 7'd0);
			send_word(OP_COUNT, sel, 16'h2a2a, 16'h0000, 7'd0);
			send_word(OP_GET_NTH, sel, 16'h2a2a, 16'h0000, 7'd64);
			send_word(OP_GET_NTH, sel, 16'h2a2a, 16'h0000, 7'd1);
			for (k = 0; k < TABLE_DEPTH / 2; k++) begin
				idx = $urandom_range(0, unit_fill[sel] - 1);
				send_word(OP_DELETE, sel, unit_tbl[sel][idx][31:16], unit_tbl[sel][idx][15:0],
					7'd0);
			end
		end
	endtask

	task automatic test_output_stall;
		int k;
		req_idle_pct = 0;
		hold_left <= 300;
		for (k = 0; k < 16; k++)
			send_word(op_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
				owner_pool[$urandom_range(0, 5)], 16'($urandom), 7'($urandom_range(0, 3)));
		req_idle_pct = 33;
	endtask

	task automatic test_random_ops(int count);
		int k;
		int r;
		int c;
		int idx;
		int app;
		logic sel;
		logic [15:0] own;
		logic [15:0] itm;
		logic [6:0] nth;
		op_t op;
		for (k = 0; k < count; k++) begin
			if (k == count / 3) begin
				req_idle_pct = 0;
				rsp_idle_pct = 0;
			end
			if (k == count / 3 + 120) begin
				req_idle_pct = 33;
				rsp_idle_pct = 33;
			end
			sel = 1'($urandom_range(0, 1));
			own = owner_pool[$urandom_range(0, 5)];
			itm = ($urandom_range(0, 3) == 0) ? owner_pool[$urandom_range(0, 5)] : 16'($urandom);
			nth = 7'($urandom_range(0, 64));
			if ($urandom_range(0, 9) == 0) begin
				op = op_t'($urandom_range(0, 3));
				own = 16'($urandom);
				itm = 16'($urandom);
			end else begin
				r = $urandom_range(0, 99);
				app = (unit_fill[sel] < 16) ? 35 : ((unit_fill[sel] > 56) ? 12 : 28);
				if (r < 20) begin
					op = OP_COUNT;
				end else if (r < 45) begin
					op = OP_GET_NTH;
					c = 0;
					for (idx = 0; idx < unit_fill[sel]; idx++) begin
						if (unit_tbl[sel][idx][31:16] == own) c++;
					end
					if ($urandom_range(0, 4) != 0) nth = 7'($urandom_range(0, c + 1));
				end else if (r < 45 + app) begin
					op = OP_APPEND;
				end else begin
					op = OP_DELETE;
					if (unit_fill[sel] > 0 && $urandom_range(0, 3) != 0) begin
						idx = $urandom_range(0, unit_fill[sel] - 1);
						own = unit_tbl[sel][idx][31:16];
						itm = unit_tbl[sel][idx][15:0];
					end
				end
			end
			send_word(op, sel, own, itm, nth);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.operation = OP_COUNT;
		req_ch.table_select = 1'b0;
		req_ch.owner_id = '0;
		req_ch.item_id = '0;
		req_ch.nth_index = '0;
		rsp_ch.ready = 1'b0;
		unit_fill[0] = 0;
		unit_fill[1] = 0;
		foreach (unit_tbl[s, i]) unit_tbl[s][i] = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_table_full();
		test_output_stall();
		test_random_ops(360);

		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) err_count++;

		if (err_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
